>>> hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types, constants and microprogram
// Widths of the modular exponentiation core, the control word layout and the
// read-only sequence of control words that drives the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_BITS  = 32;
  localparam int EXP_BITS  = 32;
  localparam int BASE_BITS = 32;
  localparam int PROD_BITS = 2 * MOD_BITS;
  localparam int RED_BITS  = (PROD_BITS > BASE_BITS) ? PROD_BITS : BASE_BITS;
  localparam int RED_STEPS = RED_BITS / 2;
  localparam int CNT_W     = $clog2(RED_STEPS);

  localparam int UCODE_DEPTH = 10;
  localparam int UPC_W       = $clog2(UCODE_DEPTH);

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    OP_BASE,
    OP_ACC_B,
    OP_B_B
  } op_t;

  typedef enum logic [1:0] {
    DEST_NONE,
    DEST_B,
    DEST_ACC
  } dest_t;

  typedef enum logic [1:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_EXP_ZERO,
    JC_BIT_CLEAR
  } jcond_t;

  typedef enum logic {
    RED_IDLE,
    RED_RUN
  } red_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mexp_status_t;

  // field order: accept, start, op, wait_done, dest, shift_e, emit, jc, target
  typedef struct packed {
    logic   accept;
    logic   start;
    op_t    op;
    logic   wait_done;
    dest_t  dest;
    logic   shift_e;
    logic   emit;
    jcond_t jc;
    upc_t   target;
  } ctrl_word_t;

  localparam upc_t STEP_IDLE   = upc_t'(0);
  localparam upc_t STEP_RBASE  = upc_t'(1);
  localparam upc_t STEP_WBASE  = upc_t'(2);
  localparam upc_t STEP_TEND   = upc_t'(3);
  localparam upc_t STEP_TBIT   = upc_t'(4);
  localparam upc_t STEP_MUL    = upc_t'(5);
  localparam upc_t STEP_WMUL   = upc_t'(6);
  localparam upc_t STEP_SQUARE = upc_t'(7);
  localparam upc_t STEP_WSQ    = upc_t'(8);
  localparam upc_t STEP_DONE   = upc_t'(9);

  localparam ctrl_word_t UCODE [UCODE_DEPTH] = '{
    // idle: take a transaction
    '{1'b1, 1'b0, OP_BASE,  1'b0, DEST_NONE, 1'b0, 1'b0, JC_NEVER,     STEP_IDLE},
    // reduce the base
    '{1'b0, 1'b1, OP_BASE,  1'b0, DEST_NONE, 1'b0, 1'b0, JC_NEVER,     STEP_IDLE},
    '{1'b0, 1'b0, OP_BASE,  1'b1, DEST_B,    1'b0, 1'b0, JC_NEVER,     STEP_IDLE},
    // loop head: finish when no exponent bits remain
    '{1'b0, 1'b0, OP_BASE,  1'b0, DEST_NONE, 1'b0, 1'b0, JC_EXP_ZERO,  STEP_DONE},
    '{1'b0, 1'b0, OP_BASE,  1'b0, DEST_NONE, 1'b0, 1'b0, JC_BIT_CLEAR, STEP_SQUARE},
    // multiply into the accumulator
    '{1'b0, 1'b1, OP_ACC_B, 1'b0, DEST_NONE, 1'b0, 1'b0, JC_NEVER,     STEP_IDLE},
    '{1'b0, 1'b0, OP_BASE,  1'b1, DEST_ACC,  1'b0, 1'b0, JC_NEVER,     STEP_IDLE},
    // square the base, advance the exponent
    '{1'b0, 1'b1, OP_B_B,   1'b0, DEST_NONE, 1'b1, 1'b0, JC_NEVER,     STEP_IDLE},
    '{1'b0, 1'b0, OP_BASE,  1'b1, DEST_B,    1'b0, 1'b0, JC_ALWAYS,    STEP_TEND},
    // hand over the result
    '{1'b0, 1'b0, OP_BASE,  1'b0, DEST_NONE, 1'b0, 1'b1, JC_ALWAYS,    STEP_IDLE}
  };

endpackage

>>> hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod: multiply and serial modular reduction unit
// Registers one product (or a raw value), then reduces it two bits a cycle
// by shift, compare and subtract. A zero modulus acts as 2^MOD_BITS.
// ----------------------------------------------------------------------------
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 mul,
  input  logic [MOD_BITS-1:0]  op_a,
  input  logic [MOD_BITS-1:0]  op_b,
  input  logic [BASE_BITS-1:0] raw,
  input  logic [MOD_BITS-1:0]  modulus,
  output mexp_status_t         status,
  output logic [MOD_BITS-1:0]  result
);

  red_state_t            state, state_next;
  logic [RED_BITS-1:0]   shreg;
  logic [MOD_BITS-1:0]   rem, rem_next;
  logic [CNT_W-1:0]      cnt;
  logic                  done;
  logic [MOD_BITS:0]     mext;
  logic [PROD_BITS-1:0]  prod;
  logic                  last;

  function automatic logic [MOD_BITS-1:0] rstep(input logic [MOD_BITS-1:0] r,
                                                input logic             bit_in,
                                                input logic [MOD_BITS:0] m);
    logic [MOD_BITS:0] t;
    t = {r, bit_in};
    if (t >= m) begin
      t = t - m;
    end
    return t[MOD_BITS-1:0];
  endfunction

  assign mext     = {(modulus == '0), modulus};
  assign prod     = PROD_BITS'(op_a) * PROD_BITS'(op_b);
  assign last     = (cnt == CNT_W'(RED_STEPS - 1));
  assign rem_next = rstep(rstep(rem, shreg[RED_BITS-1], mext), shreg[RED_BITS-2], mext);

  always_comb begin
    state_next = state;
    case (state)
      RED_IDLE: if (start) state_next = RED_RUN;
      RED_RUN:  if (last) state_next = RED_IDLE;
      default:  state_next = RED_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state == RED_RUN);
    status.done = done;
    result      = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RED_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == RED_RUN) && last;
    end
  end

  always_ff @(posedge clk) begin
    if (state == RED_IDLE && start) begin
      shreg <= mul ? RED_BITS'(prod) : RED_BITS'(raw);
      rem   <= '0;
      cnt   <= '0;
    end else if (state == RED_RUN) begin
      shreg <= shreg << 2;
      rem   <= rem_next;
      cnt   <= cnt + CNT_W'(1);
    end
  end

endmodule

>>> hdl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base^exponent mod modulus
// Right-to-left square and multiply under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Write the modulus through cfg_wr_en / cfg_wr_data while the core is idle.
//   A zero modulus acts as 2^32; exponent zero always answers 1.
//   Slave channel s_*: one transaction carries base (low word) and exponent.
//   Master channel m_*: one transaction per input carries the result.
// Timing:
//   Each modular product takes one registered multiply in the shared unit,
//   which then reduces it two reduction bits a cycle.
//   Per item: take and reduce the base, then for every exponent bit up to the
//   highest set one, the 2 test steps, the square, and the multiply before it
//   when the bit is set; then finish and hand over.
//   One item is in flight at a time; the shared reduction unit sets the rate.
// Reset:
//   rst clears the sequencer and output valid and sets the modulus to 1.
// Stall:
//   The result sits in an output register; the next item is taken while it
//   waits, and the sequencer holds at its final step only if the register is
//   still full when the next result is ready.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // modulus
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,       // [31:0] base_value, [63:32] exponent
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // [31:0] power_result
);

  // sequencer
  upc_t       upc, upc_next;
  ctrl_word_t ucode;
  logic       hold;
  logic       jump;

  // datapath
  logic [MOD_BITS-1:0]  modulus;
  logic [BASE_BITS-1:0] base_raw;
  logic [EXP_BITS-1:0]  e;
  logic [MOD_BITS-1:0]  acc;
  logic [MOD_BITS-1:0]  b;

  // reduction unit
  mexp_status_t         red_status;
  logic [MOD_BITS-1:0]  red_result;
  logic                 red_mul;
  logic [MOD_BITS-1:0]  red_a;
  logic                 emit_fire;

  assign ucode = UCODE[upc];

  // Hold the step while waiting for input, for the unit, or for output space.
  always_comb begin
    hold = (ucode.accept && !s_tvalid) ||
           (ucode.wait_done && !red_status.done) ||
           (ucode.emit && m_tvalid && !m_tready);
  end

  always_comb begin
    case (ucode.jc)
      JC_NEVER:     jump = 1'b0;
      JC_ALWAYS:    jump = 1'b1;
      JC_EXP_ZERO:  jump = (e == '0);
      JC_BIT_CLEAR: jump = !e[0];
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = ucode.target;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    case (ucode.op)
      OP_BASE:  begin red_mul = 1'b0; red_a = b;   end
      OP_ACC_B: begin red_mul = 1'b1; red_a = acc; end
      OP_B_B:   begin red_mul = 1'b1; red_a = b;   end
      default:  begin red_mul = 1'b0; red_a = b;   end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (ucode.start),
    .mul     (red_mul),
    .op_a    (red_a),
    .op_b    (b),
    .raw     (base_raw),
    .modulus (modulus),
    .status  (red_status),
    .result  (red_result)
  );

  // Modulus register: keep the low MOD_BITS bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_BITS'(1);
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data[MOD_BITS-1:0];
    end
  end

  // Working registers: load on accept, write back unit results, shift exponent.
  always_ff @(posedge clk) begin
    if (ucode.accept && s_tvalid) begin
      base_raw <= s_tdata[31:0];
      e        <= EXP_BITS'(s_tdata[63:32]);
      acc      <= MOD_BITS'(1);
    end else begin
      if (ucode.shift_e) begin
        e <= e >> 1;
      end
      if (ucode.wait_done && red_status.done) begin
        case (ucode.dest)
          DEST_B:    b   <= red_result;
          DEST_ACC:  acc <= red_result;
          DEST_NONE: ;
          default:   ;
        endcase
      end
    end
  end

  // Output register: refill when empty or being drained.
  assign emit_fire = ucode.emit && (!m_tvalid || m_tready);
  assign s_tready  = ucode.accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= 32'(acc);
    end
  end

`ifndef NO_ASSERTIONS
  // The unit finishes only while the sequencer is waiting on it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    red_status.done |-> ucode.wait_done)
    else $error("reduction finished outside a wait step");

  // A new operation never starts on a busy unit.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ucode.start |-> !red_status.busy)
    else $error("reduction started while busy");

  // A result appears only after the final step.
  a_emit_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(upc) == STEP_DONE)
    else $error("output loaded outside the final step");
`endif

endmodule
